### src/cdd_pkg.sv
`timescale 1ns / 1ps

package cdd_pkg;

    // Field widths
    localparam int ACTION_W = 4;
    localparam int COUNT_W  = 15;
    localparam int SYEAR_W  = 20;
    localparam int YEAR_W   = 21;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    // Remaining day count of a day or week move (count * 7)
    localparam int DAYN_W   = 18;
    // Residue of the year modulo 25
    localparam int RES_W    = 5;
    localparam int RES_MOD  = 25;

    // Action codes carried in the low nibble of the input item
    localparam logic [ACTION_W-1:0] ACT_DAYS           = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_WEEKS          = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_MONTHS         = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_YEARS_STEP     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_DECADES_STEP   = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_YEARS_DIRECT   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_DECADES_DIRECT = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_CENTURY        = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_MILLENNIUM     = 4'd8;

    // Request to the residue unit
    typedef struct packed {
        logic              start;
        logic [YEAR_W-1:0] value;
    } cdd_mod_req_t;

    // Status of the residue unit
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] residue;
    } cdd_mod_stat_t;

    // Month lengths of a common year, January first
    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // 4/100/400 rule from the low year bits and divisibility by 25
    function automatic logic is_leap(input logic [3:0] ylow, input logic div25);
        logic div4;
        logic div16;
        div4  = (ylow[1:0] == 2'd0);
        div16 = (ylow == 4'd0);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    // Length of a month (1..12) in a common or leap year
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [MONTH_W-1:0] idx;
        logic [DAY_W-1:0]   len;
        idx = m - 4'd1;
        if (idx > 4'd11) begin
            len = 5'd31;
        end else if (idx == 4'd1) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = MONTH_LEN[idx];
        end
        return len;
    endfunction

endpackage

### src/cdd_mod25.sv
`timescale 1ns / 1ps

// Residue of a year magnitude modulo 25 by reciprocal multiplication:
// latch the value, form the quotient, subtract 25 times it; done rises
// together with the registered remainder
module cdd_mod25 (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cdd_pkg::cdd_mod_req_t  req,
    output cdd_pkg::cdd_mod_stat_t stat
);
    import cdd_pkg::*;

    // floor(v / 25) == (v * RECIP) >> RECIP_SH for every v below 2^YEAR_W
    localparam int RECIP_SH = YEAR_W + 5;
    localparam int RECIP_W  = 22;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SH) / 64'(RES_MOD) + 64'd1);
    localparam int PROD_W   = YEAR_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - RECIP_SH;

    logic              stage1_reg;
    logic              stage2_reg;
    logic              done_reg;
    logic [YEAR_W-1:0] val_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [RES_W-1:0]  acc_reg;
    logic [QUOT_W-1:0] quot_next;
    logic [YEAR_W-1:0] mult25;
    logic [RES_W-1:0]  rem;

    // Quotient from the reciprocal, remainder from the quotient
    always_comb begin
        quot_next = QUOT_W'((PROD_W'(val_reg) * PROD_W'(RECIP)) >> RECIP_SH);
        mult25    = YEAR_W'({quot_reg, 4'b0000}) + YEAR_W'({quot_reg, 3'b000})
                  + YEAR_W'(quot_reg);
        rem       = RES_W'(val_reg - mult25);
    end

    // Control: advance the stage flags, pulse done at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            stage1_reg <= req.start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            val_reg <= req.value;
        end
        if (stage1_reg) begin
            quot_reg <= quot_next;
        end
        if (stage2_reg) begin
            acc_reg <= rem;
        end
    end

    assign stat.done    = done_reg;
    assign stat.residue = acc_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (acc_reg < RES_W'(RES_MOD)))
        else $error("residue out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> !done_reg)
        else $error("residue done right after start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("residue done longer than one cycle");

endmodule

### src/cdd_core.sv
`timescale 1ns / 1ps

// Sequencer: sanitizes the date, steps months or years one per cycle and
// uses the residue unit for the leap test of a freshly loaded year
module cdd_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cdd_pkg::ACTION_W-1:0]    action,
    input  logic [cdd_pkg::COUNT_W-1:0]     step_count,
    input  logic [cdd_pkg::SYEAR_W-1:0]     start_year,
    input  logic [cdd_pkg::MONTH_W-1:0]     start_month,
    input  logic [cdd_pkg::DAY_W-1:0]       start_day,
    output cdd_pkg::cdd_mod_req_t           mod_req,
    input  cdd_pkg::cdd_mod_stat_t          mod_stat,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic signed [cdd_pkg::YEAR_W-1:0] result_year,
    output logic [cdd_pkg::MONTH_W-1:0]     result_month,
    output logic [cdd_pkg::DAY_W-1:0]       result_day
);
    import cdd_pkg::*;

    localparam int DELTA_W = COUNT_W + 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_DISPATCH,
        ST_DAYS,
        ST_MONTHS,
        ST_YEARS,
        ST_DECADES,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic                      pass_reg, pass_next;
    logic [ACTION_W-1:0]       action_reg, action_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [DAYN_W-1:0]         n_reg, n_next;
    logic signed [YEAR_W-1:0]  y_reg, y_next;
    logic [MONTH_W-1:0]        m_reg, m_next;
    logic [DAY_W-1:0]          d_reg, d_next;
    logic [RES_W-1:0]          r_reg, r_next;

    logic                      wrap;
    logic [MONTH_W-1:0]        m_prev;
    logic signed [YEAR_W-1:0]  y_dec1, y_dec10, y_wrap, y_sub;
    logic [RES_W-1:0]          r_dec1, r_dec10, r_wrap;
    logic [DAY_W-1:0]          dim_cur, dim_prev, dim_dec1, dim_dec10;
    logic [DELTA_W-1:0]        delta;
    logic [DAYN_W-1:0]         weeks_n;
    logic [DAYN_W-1:0]         d_ext;

    // Step helpers: previous month, year minus one or ten, new month lengths
    always_comb begin
        wrap    = (m_reg == 4'd1);
        m_prev  = wrap ? 4'd12 : (m_reg - 4'd1);
        y_dec1  = y_reg - YEAR_W'(1);
        y_dec10 = y_reg - YEAR_W'(10);
        r_dec1  = (r_reg == '0) ? RES_W'(RES_MOD - 1) : (r_reg - 1'b1);
        r_dec10 = (r_reg >= RES_W'(10)) ? (r_reg - RES_W'(10))
                                         : (r_reg + RES_W'(RES_MOD - 10));
        y_wrap  = wrap ? y_dec1 : y_reg;
        r_wrap  = wrap ? r_dec1 : r_reg;
        dim_cur   = days_in(m_reg, is_leap(y_reg[3:0], r_reg == '0));
        dim_prev  = days_in(m_prev, is_leap(y_wrap[3:0], r_wrap == '0));
        dim_dec1  = days_in(m_reg, is_leap(y_dec1[3:0], r_dec1 == '0));
        dim_dec10 = days_in(m_reg, is_leap(y_dec10[3:0], r_dec10 == '0));
        d_ext     = DAYN_W'(d_reg);
        weeks_n   = {cnt_reg, 3'b000} - DAYN_W'(cnt_reg);
    end

    // Amount for the one-shot year moves
    always_comb begin
        case (action_reg)
            ACT_YEARS_DIRECT:   delta = DELTA_W'(cnt_reg);
            ACT_DECADES_DIRECT: delta = DELTA_W'({cnt_reg, 3'b000})
                                      + DELTA_W'({cnt_reg, 1'b0});
            ACT_CENTURY:        delta = DELTA_W'(100);
            ACT_MILLENNIUM:     delta = DELTA_W'(1000);
            default:            delta = '0;
        endcase
        y_sub = y_reg - $signed({{(YEAR_W-DELTA_W){1'b0}}, delta});
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        action_next = action_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        y_next      = y_reg;
        m_next      = m_reg;
        d_next      = d_reg;
        r_next      = r_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    action_next = action;
                    cnt_next    = step_count;
                    y_next      = $signed({1'b0, start_year});
                    if (start_month == 4'd0) begin
                        m_next = 4'd1;
                    end else if (start_month > 4'd12) begin
                        m_next = 4'd12;
                    end else begin
                        m_next = start_month;
                    end
                    d_next     = (start_day == '0) ? 5'd1 : start_day;
                    pass_next  = 1'b0;
                    state_next = ST_MOD_START;
                end
            end
            ST_MOD_START: begin
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (mod_stat.done) begin
                    r_next     = mod_stat.residue;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                // Clamp the day to its month, then pick the move
                if (d_reg > dim_cur) begin
                    d_next = dim_cur;
                end
                if (pass_reg) begin
                    state_next = ST_DONE;
                end else begin
                    case (action_reg) inside
                        ACT_DAYS: begin
                            n_next     = DAYN_W'(cnt_reg);
                            state_next = ST_DAYS;
                        end
                        ACT_WEEKS: begin
                            n_next     = weeks_n;
                            state_next = ST_DAYS;
                        end
                        ACT_MONTHS:       state_next = ST_MONTHS;
                        ACT_YEARS_STEP:   state_next = ST_YEARS;
                        ACT_DECADES_STEP: state_next = ST_DECADES;
                        ACT_YEARS_DIRECT, ACT_DECADES_DIRECT,
                        ACT_CENTURY, ACT_MILLENNIUM: begin
                            y_next     = y_sub;
                            pass_next  = 1'b1;
                            state_next = ST_MOD_START;
                        end
                        default:          state_next = ST_DONE;
                    endcase
                end
            end
            ST_DAYS: begin
                // Take what is left from this month, or drop a whole month
                if (n_reg == '0) begin
                    state_next = ST_DONE;
                end else if (d_ext > n_reg) begin
                    d_next = d_reg - DAY_W'(n_reg);
                    n_next = '0;
                end else begin
                    n_next = n_reg - d_ext;
                    m_next = m_prev;
                    y_next = y_wrap;
                    r_next = r_wrap;
                    d_next = dim_prev;
                end
            end
            ST_MONTHS: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                    m_next   = m_prev;
                    y_next   = y_wrap;
                    r_next   = r_wrap;
                    if (d_reg > dim_prev) begin
                        d_next = dim_prev;
                    end
                end
            end
            ST_YEARS: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                    y_next   = y_dec1;
                    r_next   = r_dec1;
                    if (d_reg > dim_dec1) begin
                        d_next = dim_dec1;
                    end
                end
            end
            ST_DECADES: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                    y_next   = y_dec10;
                    r_next   = r_dec10;
                    if (d_reg > dim_dec10) begin
                        d_next = dim_dec10;
                    end
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pass_reg   <= pass_next;
        action_reg <= action_next;
        cnt_reg    <= cnt_next;
        n_reg      <= n_next;
        y_reg      <= y_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        r_reg      <= r_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign mod_req.start = (state_reg == ST_MOD_START);
    assign mod_req.value = y_reg[YEAR_W-1] ? (-y_reg) : y_reg;
    assign result_year   = y_reg;
    assign result_month  = m_reg;
    assign result_day    = d_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (m_reg >= 4'd1 && m_reg <= 4'd12 && d_reg >= 5'd1))
        else $error("result date out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (d_reg <= dim_cur))
        else $error("result day beyond month length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DAYS || state_reg == ST_MONTHS) |-> (r_reg < RES_W'(RES_MOD)))
        else $error("year residue out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD_START) |=> (state_reg == ST_MOD_WAIT && !mod_stat.done))
        else $error("residue unit finished early");

endmodule

### src/calendar_date_decrement.sv
`timescale 1ns / 1ps

// Gregorian date decrement.
// s_ channel: one item carries action, step count and the start date.
// m_ channel: one item per input item with the resulting date.
// s_tready is high while the sequencer is idle; an item is taken, worked
// on, and its result moved into the output register, after which the next
// item is taken in the following cycle even while m_tvalid still waits for m_tready.
// Steps from the accepting edge to m_tvalid, output register empty:
//   unknown action: load, a mod-25 pass on the start year for the leap
//     test, clamp;
//   months, stepwise years and decades: as above, then one step per cycle;
//   days/weeks: as above, then one step per month crossed and one for a
//     final partial month;
//   direct years, decades, century, millennium: as for an unknown action,
//     with a second mod-25 pass on the new year.
// The one-step-per-cycle month/year walk sets the rate.
// Reset (aresetn low, synchronous) drops any item in work and any result
// not yet taken. When the receiver stalls, the result holds in the output
// register and the sequencer waits after finishing the next item.
module calendar_date_decrement (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] action, [18:4] step_count, [38:19] start_year,
    // [42:39] start_month, [47:43] start_day
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [20:0] result_year, [24:21] result_month, [29:25] result_day,
    // [31:30] zero
    output logic [31:0] m_tdata
);
    import cdd_pkg::*;

    cdd_mod_req_t               mod_req;
    cdd_mod_stat_t              mod_stat;
    logic                       res_valid;
    logic                       res_ready;
    logic signed [YEAR_W-1:0]   res_year;
    logic [MONTH_W-1:0]         res_month;
    logic [DAY_W-1:0]           res_day;

    logic                       out_valid_reg;
    logic [YEAR_W-1:0]          out_year_reg;
    logic [MONTH_W-1:0]         out_month_reg;
    logic [DAY_W-1:0]           out_day_reg;

    cdd_mod25 u_mod25 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (mod_req),
        .stat     (mod_stat)
    );

    cdd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .action       (s_tdata[3:0]),
        .step_count   (s_tdata[18:4]),
        .start_year   (s_tdata[38:19]),
        .start_month  (s_tdata[42:39]),
        .start_day    (s_tdata[47:43]),
        .mod_req      (mod_req),
        .mod_stat     (mod_stat),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .result_year  (res_year),
        .result_month (res_month),
        .result_day   (res_day)
    );

    // Load the output register when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_year_reg  <= res_year;
            out_month_reg <= res_month;
            out_day_reg   <= res_day;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_day_reg, out_month_reg, out_year_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result item changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid)
        else $error("finished item dropped while output full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input item taken while another is in work");

endmodule
